@@ sv/mmexp_pkg.sv @@
// Shared types and constants for the Montgomery modular exponentiation block.
package mmexp_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULUS     = 3'd0,
		CFG_R_MOD_N     = 3'd1,
		CFG_R_SQUARED   = 3'd2,
		CFG_PUBLIC_EXP  = 3'd3,
		CFG_PRIVATE_EXP = 3'd4
	} cfg_idx_t;

	// Register values after reset
	localparam int RST_MODULUS     = 133;
	localparam int RST_R_MOD_N     = 123;
	localparam int RST_R_SQUARED   = 100;
	localparam int RST_PUBLIC_EXP  = 5;
	localparam int RST_PRIVATE_EXP = 65;

	// Fixed payload widths of the channels
	localparam int MSG_W    = 8;
	localparam int RESULT_W = 8;

	// Which Montgomery product the datapath runs
	typedef enum logic [1:0] {
		OP_TO_MONT = 2'd0,  // sq = MM(message, R^2)
		OP_MUL     = 2'd1,  // acc = MM(acc, sq)
		OP_SQR     = 2'd2,  // sq = MM(sq, sq)
		OP_FROM    = 2'd3   // acc = MM(acc, 1)
	} mm_op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic   load;
		logic   mm_start;
		logic   mm_step;
		logic   mm_final;
		logic   exp_shift;
		logic   out_load;
		mm_op_t op;
	} mmexp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic exp_bit;
	} mmexp_status_t;

endpackage

@@ sv/mmexp_in_if.sv @@
// Input channel: valid/ready handshake carrying kind and message.
interface mmexp_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] message;

	modport source (output valid, output kind, output message, input ready);
	modport sink (input valid, input kind, input message, output ready);
endinterface

@@ sv/mmexp_out_if.sv @@
// Output channel: valid/ready handshake carrying the power result.
interface mmexp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

@@ sv/mmexp_ctrl.sv @@
// Sequencer for exponentiation: product iterations, exponent scan, output handoff.
module mmexp_ctrl #(
	parameter int WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  mmexp_pkg::mmexp_status_t status,
	output mmexp_pkg::mmexp_cmd_t    cmd
);
	import mmexp_pkg::*;

	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ITER,
		S_FIN,
		S_DECIDE,
		S_OUTPUT
	} state_t;

	state_t             state_q;
	mm_op_t             op_q;
	logic [CNT_W-1:0]   iter_q;
	logic [CNT_W-1:0]   bit_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.mm_start  = (state_q == S_START);
		cmd.mm_step   = (state_q == S_ITER);
		cmd.mm_final  = (state_q == S_FIN);
		cmd.exp_shift = (state_q == S_FIN) && (op_q == OP_SQR);
		cmd.out_load  = (state_q == S_OUTPUT) && out_free;
		cmd.op        = op_q;
	end

	// Advance the sequence and hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_TO_MONT;
			iter_q      <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_TO_MONT;
						state_q <= S_START;
					end
				end
				S_START: begin
					iter_q  <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (iter_q == LAST) begin
						state_q <= S_FIN;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				S_FIN: begin
					unique case (op_q)
						OP_TO_MONT: begin
							bit_q   <= '0;
							state_q <= S_DECIDE;
						end
						OP_MUL: begin
							op_q    <= OP_SQR;
							state_q <= S_START;
						end
						OP_SQR: begin
							if (bit_q == LAST) begin
								op_q    <= OP_FROM;
								state_q <= S_START;
							end else begin
								bit_q   <= bit_q + 1'b1;
								state_q <= S_DECIDE;
							end
						end
						OP_FROM: begin
							state_q <= S_OUTPUT;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_DECIDE: begin
					op_q    <= status.exp_bit ? OP_MUL : OP_SQR;
					state_q <= S_START;
				end
				S_OUTPUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/mmexp_dp.sv @@
// Datapath: configuration registers, radix-2 Montgomery unit and operand registers.
module mmexp_dp #(
	parameter int WIDTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [mmexp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [WIDTH-1:0]                  cfg_data,
	input  logic                              kind,
	input  logic [mmexp_pkg::MSG_W-1:0]       message,
	input  mmexp_pkg::mmexp_cmd_t             cmd,
	output mmexp_pkg::mmexp_status_t          status,
	output logic [mmexp_pkg::RESULT_W-1:0]    power_result
);
	import mmexp_pkg::*;

	localparam int PW = WIDTH + 3;  // running sum before halving
	localparam int QW = WIDTH + 2;  // partial product after halving

	logic [WIDTH-1:0]          modulus_q;
	logic [WIDTH-1:0]          r_mod_n_q;
	logic [WIDTH-1:0]          r_squared_q;
	logic [WIDTH-1:0]          pub_exp_q;
	logic [WIDTH-1:0]          priv_exp_q;

	logic [WIDTH-1:0]          exp_q;
	logic [WIDTH:0]            acc_q;
	logic [WIDTH:0]            sq_q;
	logic [WIDTH:0]            y_q;
	logic [WIDTH-1:0]          x_q;
	logic [QW-1:0]             part_q;
	logic [RESULT_W-1:0]       result_q;

	logic [WIDTH+MSG_W-1:0]    msg_ext;
	logic [WIDTH+RESULT_W-1:0] acc_ext;
	logic [PW-1:0]             sum_y;
	logic [PW-1:0]             sum_n;
	logic [QW-1:0]             mod_ext;
	logic [QW-1:0]             diff;
	logic [WIDTH:0]            mm_res;
	logic [WIDTH:0]            y_sel;
	logic [WIDTH-1:0]          x_sel;

	// Fit the fixed-width channel fields to the word width
	assign msg_ext = {{WIDTH{1'b0}}, message};
	assign acc_ext = {{RESULT_W{1'b0}}, acc_q[WIDTH-1:0]};

	// One product iteration: add y on the x bit, add N to make it even, halve
	assign sum_y = PW'(part_q) + (x_q[0] ? PW'(y_q) : '0);
	assign sum_n = sum_y + (sum_y[0] ? PW'(modulus_q) : '0);

	// Final conditional subtraction
	assign mod_ext = QW'(modulus_q);
	assign diff    = part_q - mod_ext;
	assign mm_res  = (part_q >= mod_ext) ? diff[WIDTH:0] : part_q[WIDTH:0];

	// Select operands of the next product
	always_comb begin
		case (cmd.op)
			OP_TO_MONT: begin
				y_sel = sq_q;
				x_sel = r_squared_q;
			end
			OP_MUL: begin
				y_sel = acc_q;
				x_sel = sq_q[WIDTH-1:0];
			end
			OP_SQR: begin
				y_sel = sq_q;
				x_sel = sq_q[WIDTH-1:0];
			end
			default: begin
				y_sel = acc_q;
				x_sel = WIDTH'(1);
			end
		endcase
	end

	// Hold configuration, to be written only while idle; not enforced by the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= WIDTH'(RST_MODULUS);
			r_mod_n_q   <= WIDTH'(RST_R_MOD_N);
			r_squared_q <= WIDTH'(RST_R_SQUARED);
			pub_exp_q   <= WIDTH'(RST_PUBLIC_EXP);
			priv_exp_q  <= WIDTH'(RST_PRIVATE_EXP);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MODULUS:     modulus_q   <= cfg_data;
				CFG_R_MOD_N:     r_mod_n_q   <= cfg_data;
				CFG_R_SQUARED:   r_squared_q <= cfg_data;
				CFG_PUBLIC_EXP:  pub_exp_q   <= cfg_data;
				CFG_PRIVATE_EXP: priv_exp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand, product and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sq_q  <= {1'b0, msg_ext[WIDTH-1:0]};
			acc_q <= {1'b0, r_mod_n_q};
			exp_q <= kind ? priv_exp_q : pub_exp_q;
		end
		if (cmd.mm_start) begin
			y_q    <= y_sel;
			x_q    <= x_sel;
			part_q <= '0;
		end
		if (cmd.mm_step) begin
			part_q <= sum_n[PW-1:1];
			x_q    <= x_q >> 1;
		end
		if (cmd.mm_final) begin
			if (cmd.op == OP_TO_MONT || cmd.op == OP_SQR) begin
				sq_q <= mm_res;
			end else begin
				acc_q <= mm_res;
			end
		end
		if (cmd.exp_shift) begin
			exp_q <= exp_q >> 1;
		end
		if (cmd.out_load) begin
			result_q <= acc_ext[RESULT_W-1:0];
		end
	end

	assign status.exp_bit = exp_q[0];
	assign power_result   = result_q;

endmodule

@@ sv/montgomery_modular_exponentiation.sv @@
// Top level of the Montgomery modular exponentiation block.
//
// Usage: write the modulus N, R mod N, R^2 mod N and the two exponents through
// the configuration port (cfg_write, cfg_index, cfg_data) while the block is
// idle. Each transaction on req carries a kind bit (0 public, 1 private
// exponent) and a message below N; one transaction on rsp returns
// message^exponent mod N.
// Every Montgomery product runs in the shared bit-serial unit (load, WIDTH
// add-and-halve steps, final subtraction). One item runs 2 + WIDTH +
// popcount(e) products, with a decision step before each exponent bit, plus
// an accept state and an output state. Items are worked one at a time;
// req.ready is high only while the sequencer is idle.
// The result sits in an output register, so a new item is taken while rsp
// stalls; a finished item waits in the sequencer until the register frees up.
// Reset: clears the sequencer and rsp.valid and loads the default register
// values (N = 133, R mod N = 123, R^2 mod N = 100, exponents 5 and 65).
module montgomery_modular_exponentiation #(
	parameter int WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [mmexp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDTH-1:0]                cfg_data,
	mmexp_in_if.sink                        req,
	mmexp_out_if.source                     rsp
);
	import mmexp_pkg::*;

	mmexp_cmd_t    cmd;
	mmexp_status_t status;

	// Sequencer
	mmexp_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath
	mmexp_dp #(
		.WIDTH(WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (req.kind),
		.message      (req.message),
		.cmd          (cmd),
		.status       (status),
		.power_result (rsp.power_result)
	);

endmodule

@@ sv/mmexp_checker.sv @@
// Port-level assertions for the exponentiation block and their bind.
module mmexp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] power_result
);

	// Hold a stalled result valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// Hold a stalled result value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(power_result))
		else $error("result changed while stalled");

	// Drop ready once an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while busy");

	// No result appears right after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result raised one cycle after accept");

endmodule

bind montgomery_modular_exponentiation mmexp_checker u_mmexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.power_result (rsp.power_result)
);
